// ----- rtl/core/fwsk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsk_pkg
// shared widths, constants and tables for the four wheel steering kinematics
// ----------------------------------------------------------------------------
package fwsk_pkg;

    localparam int VW       = 34;   // contact velocity and cordic x/y width
    localparam int ZW       = 26;   // cordic angle width, q.24 rad
    localparam int ATAN_LEN = 24;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    localparam logic [2:0] REG_INV_RADIUS = 3'd4;
    localparam logic [2:0] REG_STEER_LIM  = 3'd5;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
        logic neg;
        logic zero;
    } cordic_t;

    function automatic logic [ZW-1:0] atan_q24(input logic [4:0] i);
        logic [ZW-1:0] r;
        unique case (i)
            5'd0:    r = 26'd13176795;
            5'd1:    r = 26'd7778716;
            5'd2:    r = 26'd4110060;
            5'd3:    r = 26'd2086331;
            5'd4:    r = 26'd1047214;
            5'd5:    r = 26'd524117;
            5'd6:    r = 26'd262123;
            5'd7:    r = 26'd131069;
            5'd8:    r = 26'd65536;
            5'd9:    r = 26'd32768;
            5'd10:   r = 26'd16384;
            5'd11:   r = 26'd8192;
            5'd12:   r = 26'd4096;
            5'd13:   r = 26'd2048;
            5'd14:   r = 26'd1024;
            5'd15:   r = 26'd512;
            5'd16:   r = 26'd256;
            5'd17:   r = 26'd128;
            5'd18:   r = 26'd64;
            5'd19:   r = 26'd32;
            5'd20:   r = 26'd16;
            5'd21:   r = 26'd8;
            5'd22:   r = 26'd4;
            5'd23:   r = 26'd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/fwsk_cordic_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsk_cordic_stage
// one registered vectoring micro-rotation of the cordic pipeline
// ----------------------------------------------------------------------------
module fwsk_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fwsk_pkg::cordic_t in_data,
    output logic              out_valid,
    output fwsk_pkg::cordic_t out_data
);

    fwsk_pkg::cordic_t data_next;
    fwsk_pkg::vec_t    xs;
    fwsk_pkg::vec_t    ys;
    fwsk_pkg::ang_t    at;
    logic              valid_reg;
    fwsk_pkg::cordic_t data_reg;

    always_comb
    begin
        xs = in_data.x >>> SHIFT;
        ys = in_data.y >>> SHIFT;
        at = fwsk_pkg::atan_q24(5'(SHIFT));
        data_next = in_data;
        if (!in_data.y[fwsk_pkg::VW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + at;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/fwsk_wheel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsk_wheel
// per-wheel pipeline: contact velocity, fold, cordic, angle clamp, drive rate
// ----------------------------------------------------------------------------
module fwsk_wheel #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] lin_vel_x,
    input  logic signed [15:0] lin_vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic [31:0]        wheel_pos,
    input  logic [15:0]        inv_wheel_radius,
    input  logic [13:0]        steer_limit,
    output logic               out_valid,
    output logic signed [14:0] steer_angle,
    output logic signed [23:0] drive_rate
);

    localparam int NST = (CORDIC_STAGES < fwsk_pkg::ATAN_LEN) ?
                         CORDIC_STAGES : fwsk_pkg::ATAN_LEN;

    // stage 1: yaw products
    logic               v1_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] px_reg;
    logic signed [15:0] lx_reg;
    logic signed [15:0] ly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        py_reg <= yaw_rate * $signed(wheel_pos[31:16]);
        px_reg <= yaw_rate * $signed(wheel_pos[15:0]);
        lx_reg <= lin_vel_x;
        ly_reg <= lin_vel_y;
    end

    // stage 2: contact velocity and fold by pi
    fwsk_pkg::vec_t    vx;
    fwsk_pkg::vec_t    vy;
    fwsk_pkg::cordic_t c_next;
    logic              v2_reg;
    fwsk_pkg::cordic_t c2_reg;

    always_comb
    begin
        vx = fwsk_pkg::VW'($signed({lx_reg, 12'd0})) - fwsk_pkg::VW'(py_reg);
        vy = fwsk_pkg::VW'($signed({ly_reg, 12'd0})) + fwsk_pkg::VW'(px_reg);
        c_next.zero = (vx == '0) && (vy == '0);
        c_next.neg  = vx[fwsk_pkg::VW-1];
        c_next.x    = c_next.neg ? -vx : vx;
        c_next.y    = c_next.neg ? -vy : vy;
        c_next.z    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        c2_reg <= c_next;
    end

    // cordic chain
    logic              cv [0:NST];
    fwsk_pkg::cordic_t cd [0:NST];

    assign cv[0] = v2_reg;
    assign cd[0] = c2_reg;

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        fwsk_cordic_stage #(.SHIFT(g)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cv[g]),
            .in_data  (cd[g]),
            .out_valid(cv[g+1]),
            .out_data (cd[g+1])
        );
    end

    // post stage a: angle rounding and clamp, gain multiply
    fwsk_pkg::cordic_t  cf;
    logic signed [15:0] ang_r;
    logic signed [15:0] lim;
    logic signed [14:0] ang_next;
    logic [32:0]        xpos;
    logic               va_reg;
    logic signed [14:0] ang_a_reg;
    logic [62:0]        mag_a_reg;
    logic               neg_a_reg;
    logic               zero_a_reg;

    always_comb
    begin
        cf    = cd[NST];
        ang_r = 16'((cf.z + fwsk_pkg::ZW'(1024)) >>> 11);
        lim   = $signed({2'b00, steer_limit});
        if (ang_r > lim)
            ang_next = 15'(lim);
        else if (ang_r < -lim)
            ang_next = 15'(-lim);
        else
            ang_next = 15'(ang_r);
        xpos = cf.x[fwsk_pkg::VW-1] ? '0 : cf.x[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= cv[NST];
    end

    always_ff @(posedge clk)
    begin
        ang_a_reg  <= ang_next;
        mag_a_reg  <= xpos * fwsk_pkg::INV_GAIN_Q30;
        neg_a_reg  <= cf.neg;
        zero_a_reg <= cf.zero;
    end

    // post stage b: radius multiply
    logic [32:0] mag;
    logic        vb_reg;
    logic [14:0] ang_b_reg;
    logic [48:0] r_b_reg;
    logic        neg_b_reg;
    logic        zero_b_reg;

    assign mag = 33'((mag_a_reg + 63'(1) * (63'd1 << 29)) >> 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        ang_b_reg  <= ang_a_reg;
        r_b_reg    <= mag * inv_wheel_radius;
        neg_b_reg  <= neg_a_reg;
        zero_b_reg <= zero_a_reg;
    end

    // post stage c: round and saturate
    logic [29:0]        r;
    logic signed [23:0] d_next;
    logic               vc_reg;
    logic signed [14:0] ang_c_reg;
    logic signed [23:0] d_c_reg;

    always_comb
    begin
        r = 30'((r_b_reg + (49'd1 << 19)) >> 20);
        if (neg_b_reg)
            d_next = (r > 30'd8388608) ? 24'sh800000 : 24'(-$signed({1'b0, r}));
        else
            d_next = (r > 30'd8388607) ? 24'sh7fffff : 24'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        ang_c_reg <= zero_b_reg ? '0 : ang_b_reg;
        d_c_reg   <= zero_b_reg ? '0 : d_next;
    end

    assign out_valid   = vc_reg;
    assign steer_angle = ang_c_reg;
    assign drive_rate  = d_c_reg;

endmodule

// ----- rtl/core/four_wheel_steer_kinematics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_steer_kinematics
// swerve drive inverse kinematics: body velocity to steer angle and spin rate
// ----------------------------------------------------------------------------
// A command is taken on every cycle that start is high; busy never rises.
// Each command gives one result, shown for one cycle with done high, through
// the per-wheel pipeline (the cordic stage count is capped at 24): one yaw
// multiply stage, one fold stage, one stage per cordic rotation and three
// stages for angle clamp and drive rate.
// Results cannot be held off.
module four_wheel_steer_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] lin_vel_x,
    input  logic signed [15:0] lin_vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [14:0] steer_angle_0,
    output logic signed [14:0] steer_angle_1,
    output logic signed [14:0] steer_angle_2,
    output logic signed [14:0] steer_angle_3,
    output logic signed [23:0] drive_rate_0,
    output logic signed [23:0] drive_rate_1,
    output logic signed [23:0] drive_rate_2,
    output logic signed [23:0] drive_rate_3
);

    logic [31:0] wheel_pos_reg [0:3];
    logic [15:0] inv_radius_reg;
    logic [13:0] steer_limit_reg;
    logic        vout [0:3];
    logic signed [14:0] ang [0:3];
    logic signed [23:0] drv [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                wheel_pos_reg[i] <= '0;
            inv_radius_reg  <= 16'd2560;
            steer_limit_reg <= 14'd12868;
        end
        else if (cfg_we)
        begin
            if (!cfg_index[2])
                wheel_pos_reg[cfg_index[1:0]] <= cfg_data;
            else if (cfg_index == fwsk_pkg::REG_INV_RADIUS)
                inv_radius_reg <= cfg_data[15:0];
            else if (cfg_index == fwsk_pkg::REG_STEER_LIM)
                steer_limit_reg <= cfg_data[13:0];
        end
    end

    for (genvar w = 0; w < 4; w++)
    begin : g_wheel
        fwsk_wheel #(.CORDIC_STAGES(CORDIC_STAGES)) u_wheel (
            .clk             (clk),
            .rst_n           (rst_n),
            .in_valid        (start),
            .lin_vel_x       (lin_vel_x),
            .lin_vel_y       (lin_vel_y),
            .yaw_rate        (yaw_rate),
            .wheel_pos       (wheel_pos_reg[w]),
            .inv_wheel_radius(inv_radius_reg),
            .steer_limit     (steer_limit_reg),
            .out_valid       (vout[w]),
            .steer_angle     (ang[w]),
            .drive_rate      (drv[w])
        );
    end

    assign busy          = 1'b0;
    assign done          = vout[0] & vout[1] & vout[2] & vout[3];
    assign steer_angle_0 = ang[0];
    assign steer_angle_1 = ang[1];
    assign steer_angle_2 = ang[2];
    assign steer_angle_3 = ang[3];
    assign drive_rate_0  = drv[0];
    assign drive_rate_1  = drv[1];
    assign drive_rate_2  = drv[2];
    assign drive_rate_3  = drv[3];

endmodule
